// ----- sv/spectral_grain_sorter_macros.svh -----
// assertion helpers shared by the sorter modules
`ifndef SPECTRAL_GRAIN_SORTER_MACROS_SVH
`define SPECTRAL_GRAIN_SORTER_MACROS_SVH

// same-cycle implication, reset masked
`define SGS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sgs check failed");

// next-cycle implication, reset masked
`define SGS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sgs check failed");

`endif

// ----- sv/sgs_pkg.sv -----
package sgs_pkg;

    localparam int CFG_W = 9;

    // configuration register indexes
    localparam logic [1:0] REG_ROTATION    = 2'd0;
    localparam logic [1:0] REG_GRAIN_COUNT = 2'd1;
    localparam logic [1:0] REG_DESCENDING  = 2'd2;

    typedef struct packed {
        logic signed [8:0] rotation;
        logic [8:0]        grain_count;
        logic              descending;
    } sgs_cfg_t;

    // classification of one queued beat
    typedef struct packed {
        logic first;   // frame position zero
        logic body;    // positions 1..half frame
        logic last;    // final position of the frame
    } sgs_tag_t;

endpackage

// ----- sv/sgs_front.sv -----
`include "spectral_grain_sorter_macros.svh"

module sgs_front #(
    parameter int HALF_FRAME  = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [SAMPLE_BITS-1:0]      in_sample,
    output logic                               q_valid,
    input  logic                               q_pop,
    output logic signed [SAMPLE_BITS-1:0]      q_sample,
    output logic [$clog2(HALF_FRAME)-1:0]      q_idx,
    output sgs_pkg::sgs_tag_t                  q_tag
);
    import sgs_pkg::*;

    localparam int IW    = $clog2(HALF_FRAME);
    localparam int PW    = $clog2(2 * HALF_FRAME);
    localparam int DEPTH = 4;
    localparam int DW    = $clog2(DEPTH);

    localparam logic [PW-1:0] POS_LAST = PW'(2 * HALF_FRAME - 1);
    localparam logic [PW-1:0] POS_HALF = PW'(HALF_FRAME);

    logic [PW-1:0] pos_reg, pos_next;
    logic [DW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [DW:0]   count_reg, count_next;

    logic signed [SAMPLE_BITS-1:0] smp_mem [DEPTH];
    logic [IW-1:0]                 idx_mem [DEPTH];
    sgs_tag_t                      tag_mem [DEPTH];

    logic     accept;
    sgs_tag_t tag_new;

    assign in_stall = (count_reg == (DW+1)'(DEPTH));
    assign accept   = in_valid && !in_stall;

    // classify by frame position
    always_comb
    begin
        tag_new.first = (pos_reg == '0);
        tag_new.body  = (pos_reg != '0) && (pos_reg <= POS_HALF);
        tag_new.last  = (pos_reg == POS_LAST);
    end

    always_comb
    begin
        pos_next    = pos_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            pos_next    = tag_new.last ? '0 : pos_reg + PW'(1);
            wr_ptr_next = wr_ptr_reg + DW'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + DW'(1);
        end
        case ({accept, q_pop})
            2'b10:   count_next = count_reg + (DW+1)'(1);
            2'b01:   count_next = count_reg - (DW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_mem[wr_ptr_reg] <= in_sample;
            idx_mem[wr_ptr_reg] <= IW'(pos_reg - PW'(1));
            tag_mem[wr_ptr_reg] <= tag_new;
        end
    end

    assign q_valid  = (count_reg != '0);
    assign q_sample = smp_mem[rd_ptr_reg];
    assign q_idx    = idx_mem[rd_ptr_reg];
    assign q_tag    = tag_mem[rd_ptr_reg];

    `SGS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= (DW+1)'(DEPTH))
    `SGS_ASSERT_NXT(a_count_grow, clk, rst_n, accept && !q_pop,
        count_reg == $past(count_reg) + (DW+1)'(1))
    `SGS_ASSERT_IMP(a_stall_has_data, clk, rst_n, in_stall, q_valid)

endmodule

// ----- sv/sgs_back.sv -----
`include "spectral_grain_sorter_macros.svh"

module sgs_back #(
    parameter int HALF_FRAME  = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sgs_pkg::sgs_cfg_t                  cfg,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  logic signed [SAMPLE_BITS-1:0]      q_sample,
    input  logic [$clog2(HALF_FRAME)-1:0]      q_idx,
    input  sgs_pkg::sgs_tag_t                  q_tag,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [SAMPLE_BITS-1:0]      out_sample,
    output logic                               frame_last
);
    import sgs_pkg::*;

    localparam int IW   = $clog2(HALF_FRAME);
    localparam int MD   = 1 << IW;
    localparam int LW   = IW + 2;
    localparam int NB   = $clog2(HALF_FRAME + 1);
    localparam int CW   = $clog2(NB);
    localparam int RW   = (IW + 2 > 10) ? IW + 2 : 10;
    localparam int GW   = 10;

    localparam logic [LW-1:0] N_L    = LW'(HALF_FRAME);
    localparam logic [NB-1:0] N_BITS = NB'(HALF_FRAME);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_EMIT  = 4'd1;
    localparam logic [3:0] B_DIV   = 4'd2;
    localparam logic [3:0] B_ROT   = 4'd3;
    localparam logic [3:0] B_PRD   = 4'd4;
    localparam logic [3:0] B_PWR   = 4'd5;
    localparam logic [3:0] B_GRAIN = 4'd6;
    localparam logic [3:0] B_RUN   = 4'd7;
    localparam logic [3:0] B_MRD   = 4'd8;
    localparam logic [3:0] B_MWR   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       have_reg, have_next;
    logic       src_sel_reg, src_sel_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic       frame_last_reg, frame_last_next;
    sgs_tag_t   cur_tag_reg, cur_tag_next;
    logic signed [SAMPLE_BITS-1:0] col0_reg, col0_next, res0_reg, res0_next;

    logic [8:0]      rem_reg, rem_next;
    logic [NB-1:0]   quot_reg, quot_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic signed [RW-1:0] r_reg, r_next;
    logic [LW-1:0]   j_reg, j_next;
    logic [LW-1:0]   w_reg, w_next, gl_reg, gl_next, gh_reg, gh_next, lo_reg, lo_next;
    logic [LW-1:0]   i_reg, i_next, iend_reg, iend_next, k_reg, k_next;
    logic [LW-1:0]   kend_reg, kend_next, o_reg, o_next;
    logic [GW-1:0]   gidx_reg, gidx_next;

    // memories
    logic signed [SAMPLE_BITS-1:0] col_mem [MD];
    logic signed [SAMPLE_BITS-1:0] a_mem [MD];
    logic signed [SAMPLE_BITS-1:0] b_mem [MD];
    logic signed [SAMPLE_BITS-1:0] col_rd, a_rd0, a_rd1, b_rd0, b_rd1;

    logic          col_we, a_we, b_we;
    logic [IW-1:0] col_ra, ra0, ra1, a_wa, b_wa;
    logic signed [SAMPLE_BITS-1:0] a_wd, b_wd, src_l, src_r, pick;

    logic [8:0]    gcnt;
    logic [9:0]    rem_sh;
    logic          rem_ge;
    logic [LW-1:0] mid_c, end_c, w_dbl;
    logic          take_left;

    assign gcnt   = (cfg.grain_count == '0) ? 9'd1 : cfg.grain_count;
    assign rem_sh = {rem_reg, N_BITS[cnt_reg]};
    assign rem_ge = (rem_sh >= {1'b0, gcnt});
    assign w_dbl  = w_reg << 1;
    assign mid_c  = ((lo_reg + w_reg) < gh_reg) ? lo_reg + w_reg : gh_reg;
    assign end_c  = ((lo_reg + w_dbl) < gh_reg) ? lo_reg + w_dbl : gh_reg;
    assign src_l  = src_sel_reg ? b_rd0 : a_rd0;
    assign src_r  = src_sel_reg ? b_rd1 : a_rd1;
    assign take_left = (k_reg >= kend_reg) ||
                       ((i_reg < iend_reg) &&
                        (cfg.descending ? (src_l >= src_r) : (src_l <= src_r)));
    assign pick   = take_left ? src_l : src_r;

    assign col_ra = IW'(r_reg);
    assign ra0    = (state_reg == B_IDLE) ? q_idx : IW'(i_reg);
    assign ra1    = IW'(k_reg);

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && out_stall;
        have_next       = have_reg;
        src_sel_next    = src_sel_reg;
        out_sample_next = out_sample_reg;
        frame_last_next = frame_last_reg;
        cur_tag_next    = cur_tag_reg;
        col0_next       = col0_reg;
        res0_next       = res0_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        cnt_next        = cnt_reg;
        r_next          = r_reg;
        j_next          = j_reg;
        w_next          = w_reg;
        gl_next         = gl_reg;
        gh_next         = gh_reg;
        lo_next         = lo_reg;
        i_next          = i_reg;
        iend_next       = iend_reg;
        k_next          = k_reg;
        kend_next       = kend_reg;
        o_next          = o_reg;
        gidx_next       = gidx_reg;
        q_pop           = 1'b0;
        col_we          = 1'b0;
        a_we            = 1'b0;
        b_we            = 1'b0;
        a_wa            = IW'(o_reg);
        b_wa            = IW'(o_reg);
        a_wd            = pick;
        b_wd            = pick;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop        = 1'b1;
                    cur_tag_next = q_tag;
                    col_we       = q_tag.body;
                    if (q_tag.first)
                    begin
                        col0_next = q_sample;
                    end
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                out_valid_next  = 1'b1;
                frame_last_next = cur_tag_reg.last;
                if (!have_reg)
                begin
                    out_sample_next = '0;
                end
                else if (cur_tag_reg.first)
                begin
                    out_sample_next = res0_reg;
                end
                else if (cur_tag_reg.body)
                begin
                    out_sample_next = src_sel_reg ? b_rd0 : a_rd0;
                end
                else
                begin
                    out_sample_next = '0;
                end
                if (cur_tag_reg.last)
                begin
                    res0_next  = col0_reg;
                    rem_next   = '0;
                    quot_next  = '0;
                    cnt_next   = CW'(NB - 1);
                    state_next = B_DIV;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            // grain size: one quotient bit per cycle
            B_DIV:
            begin
                rem_next = rem_ge ? 9'(rem_sh - {1'b0, gcnt}) : rem_sh[8:0];
                quot_next[cnt_reg] = rem_ge;
                if (cnt_reg == '0)
                begin
                    r_next     = RW'(cfg.rotation);
                    state_next = B_ROT;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            // bring rotation into 0..N-1
            B_ROT:
            begin
                if (r_reg[RW-1])
                begin
                    r_next = r_reg + $signed(RW'(HALF_FRAME));
                end
                else if ($unsigned(r_reg) >= RW'(HALF_FRAME))
                begin
                    r_next = r_reg - $signed(RW'(HALF_FRAME));
                end
                else
                begin
                    j_next     = '0;
                    state_next = B_PRD;
                end
            end
            B_PRD:
            begin
                state_next = B_PWR;
            end
            B_PWR:
            begin
                a_we = 1'b1;
                a_wa = IW'(j_reg);
                a_wd = col_rd;
                if (j_reg == N_L - LW'(1))
                begin
                    w_next       = LW'(1);
                    gidx_next    = '0;
                    gl_next      = '0;
                    src_sel_next = 1'b0;
                    state_next   = B_GRAIN;
                end
                else
                begin
                    j_next     = j_reg + LW'(1);
                    r_next     = ($unsigned(r_reg) == RW'(HALF_FRAME - 1)) ? '0
                                 : r_reg + $signed(RW'(1));
                    state_next = B_PRD;
                end
            end
            B_GRAIN:
            begin
                if (gidx_reg == {1'b0, gcnt})
                begin
                    // pass done, destination becomes source
                    src_sel_next = !src_sel_reg;
                    gidx_next    = '0;
                    gl_next      = '0;
                    if (w_dbl >= N_L)
                    begin
                        have_next  = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        w_next     = w_dbl;
                        state_next = B_GRAIN;
                    end
                end
                else
                begin
                    gh_next = (gidx_reg == {1'b0, gcnt} - GW'(1)) ? N_L
                              : gl_reg + LW'(quot_reg);
                    lo_next    = gl_reg;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (lo_reg >= gh_reg)
                begin
                    gl_next    = gh_reg;
                    gidx_next  = gidx_reg + GW'(1);
                    state_next = B_GRAIN;
                end
                else
                begin
                    i_next     = lo_reg;
                    iend_next  = mid_c;
                    k_next     = mid_c;
                    kend_next  = end_c;
                    o_next     = lo_reg;
                    state_next = B_MRD;
                end
            end
            B_MRD:
            begin
                state_next = B_MWR;
            end
            // merge one element into the other buffer
            B_MWR:
            begin
                a_we = src_sel_reg;
                b_we = !src_sel_reg;
                if (take_left)
                begin
                    i_next = i_reg + LW'(1);
                end
                else
                begin
                    k_next = k_reg + LW'(1);
                end
                o_next = o_reg + LW'(1);
                if (o_reg + LW'(1) == kend_reg)
                begin
                    lo_next    = kend_reg;
                    state_next = B_RUN;
                end
                else
                begin
                    state_next = B_MRD;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            src_sel_reg   <= 1'b0;
            rem_reg       <= '0;
            quot_reg      <= '0;
            cnt_reg       <= '0;
            r_reg         <= '0;
            j_reg         <= '0;
            w_reg         <= '0;
            gl_reg        <= '0;
            gh_reg        <= '0;
            lo_reg        <= '0;
            i_reg         <= '0;
            iend_reg      <= '0;
            k_reg         <= '0;
            kend_reg      <= '0;
            o_reg         <= '0;
            gidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            have_reg      <= have_next;
            src_sel_reg   <= src_sel_next;
            rem_reg       <= rem_next;
            quot_reg      <= quot_next;
            cnt_reg       <= cnt_next;
            r_reg         <= r_next;
            j_reg         <= j_next;
            w_reg         <= w_next;
            gl_reg        <= gl_next;
            gh_reg        <= gh_next;
            lo_reg        <= lo_next;
            i_reg         <= i_next;
            iend_reg      <= iend_next;
            k_reg         <= k_next;
            kend_reg      <= kend_next;
            o_reg         <= o_next;
            gidx_reg      <= gidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        frame_last_reg <= frame_last_next;
        cur_tag_reg    <= cur_tag_next;
        col0_reg       <= col0_next;
        res0_reg       <= res0_next;
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[q_idx] <= q_sample;
        end
        col_rd <= col_mem[col_ra];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_wa] <= a_wd;
        end
        a_rd0 <= a_mem[ra0];
        a_rd1 <= a_mem[ra1];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_wa] <= b_wd;
        end
        b_rd0 <= b_mem[ra0];
        b_rd1 <= b_mem[ra1];
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign frame_last = frame_last_reg;

    `SGS_ASSERT_IMP(a_pop_has_data, clk, rst_n, q_pop, q_valid)
    `SGS_ASSERT_IMP(a_emit_slot_free, clk, rst_n, state_reg == B_EMIT, !out_valid_reg)
    `SGS_ASSERT_IMP(a_merge_in_run, clk, rst_n, state_reg == B_MWR,
        (o_reg < kend_reg) && (kend_reg <= N_L))

endmodule

// ----- sv/spectral_grain_sorter.sv -----
// a beat taken from the queue passes through the emit state into the output register
// inside a frame the back end takes a new beat only once its output slot is free again
// after the frame's last beat the back end rotates and sorts the bins, while the
// 4-deep queue keeps taking beats until it fills and stalls the input
// reset: position, queue and sorter clear, registers go to rotation 0, one grain, ascending;
// outputs are zero until the first frame has been sorted
module spectral_grain_sorter #(
    parameter int HALF_FRAME  = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [sgs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    in_sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [SAMPLE_BITS-1:0]    out_sample,
    output logic                             frame_last
);
    import sgs_pkg::*;

    localparam int IW = $clog2(HALF_FRAME);

    // configuration registers; the user writes them only while idle, the block itself does not enforce this
    sgs_cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROTATION:    cfg_next.rotation    = $signed(cfg_data);
                REG_GRAIN_COUNT: cfg_next.grain_count = cfg_data;
                REG_DESCENDING:  cfg_next.descending  = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation    <= '0;
            cfg_reg.grain_count <= 9'd1;
            cfg_reg.descending  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // queue between front and back
    logic                          q_valid;
    logic                          q_pop;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic [IW-1:0]                 q_idx;
    sgs_tag_t                      q_tag;

    // front: tracks frame position, tags each beat, buffers it
    sgs_front #(
        .HALF_FRAME  (HALF_FRAME),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_sample (in_sample),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_sample  (q_sample),
        .q_idx     (q_idx),
        .q_tag     (q_tag)
    );

    // back: collects bins, answers from the sorted frame, sorts at frame end
    sgs_back #(
        .HALF_FRAME  (HALF_FRAME),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_sample   (q_sample),
        .q_idx      (q_idx),
        .q_tag      (q_tag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .frame_last (frame_last)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import sgs_pkg::*;

    localparam int N        = 256;
    localparam int FRAME    = 2 * N;
    localparam int SB       = 24;
    localparam int FRAMES   = 3;
    localparam int ITEMS    = 1200;
    // worst back-end sort after a frame end, with margin
    localparam int SORT_WAIT = 20000;
    localparam int WATCHDOG  = 100000;

    typedef struct {
        logic signed [SB-1:0] sample;
        logic signed [SB-1:0] want_sample;
        logic                 want_last;
    } row_t;

    typedef struct {
        logic signed [SB-1:0] sample;
        logic                 last;
    } beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = REG_ROTATION;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic signed [SB-1:0]  in_sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [SB-1:0]  out_sample;
    logic                  frame_last;

    always #6 clk = ~clk;

    spectral_grain_sorter #(.HALF_FRAME(N), .SAMPLE_BITS(SB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_sample(out_sample), .frame_last(frame_last)
    );

    // sorter model state
    logic signed [SB-1:0] gather_bins [0:N];
    logic signed [SB-1:0] sorted_bins [0:N];
    int                   frame_pos;
    logic signed [8:0]    m_rotation;
    logic [8:0]           m_grains;
    logic                 m_descending;

    beat_t pending_beats [$];
    int    errors = 0;
    int    beats_in = 0;
    int    beats_out = 0;
    bit    long_hold;

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // insertion sort of sorted_bins[lo..hi)
    task automatic sort_grain(input int lo, input int hi, input bit down);
        int i;
        int k;
        logic signed [SB-1:0] v;
        for (i = lo + 1; i < hi; i++) begin
            v = sorted_bins[i];
            k = i;
            while (k > lo && (down ? (sorted_bins[k-1] < v) : (sorted_bins[k-1] > v))) begin
                sorted_bins[k] = sorted_bins[k-1];
                k--;
            end
            sorted_bins[k] = v;
        end
    endtask

    // rotate the gathered bins and sort each grain, as done at frame end
    task automatic sort_frame();
        int j;
        int r;
        int g;
        int gsize;
        sorted_bins[0] = gather_bins[0];
        for (j = 0; j < N; j++) begin
            r = (j + int'(m_rotation)) % N;
            if (r < 0)
                r += N;
            sorted_bins[1+j] = gather_bins[1+r];
        end
        // zero grains act as one grain
        g = (m_grains == 0) ? 1 : int'(m_grains);
        gsize = N / g;
        for (j = 0; j + 1 < g; j++)
            sort_grain(1 + gsize * j, 1 + gsize * (j + 1), m_descending);
        // last grain takes the remainder, or all bins when grains outnumber bins
        sort_grain(1 + gsize * (g - 1), N + 1, m_descending);
    endtask

    // one accepted input beat: returns the beat it should produce
    function automatic beat_t frame_beat(input logic signed [SB-1:0] x);
        beat_t b;
        b.sample = '0;
        if (frame_pos <= N) begin
            b.sample = sorted_bins[frame_pos];
            gather_bins[frame_pos] = x;
        end
        b.last = (frame_pos == FRAME - 1);
        return b;
    endfunction

    task automatic take_beat(input logic signed [SB-1:0] x);
        beat_t b;
        b = frame_beat(x);
        pending_beats.push_back(b);
        if (frame_pos == FRAME - 1) begin
            sort_frame();
            frame_pos = 0;
        end else begin
            frame_pos++;
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ROTATION:    m_rotation   = val;
            REG_GRAIN_COUNT: m_grains     = val;
            REG_DESCENDING:  m_descending = val[0];
            default: ;
        endcase
    endtask

    // wait for the output side to drain and the back end to finish sorting
    task automatic drain();
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SORT_WAIT) @(posedge clk);
    endtask

    // offer one beat after a random gap; returns once accepted
    task automatic send(input logic signed [SB-1:0] x);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0)
            gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= x;
        do @(posedge clk); while (in_stall);
        beats_in++;
    endtask

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1, 2: return $signed(24'($urandom_range(0, 6))) - 24'sd3;  // lots of ties
            default: return 24'($urandom);
        endcase
    endfunction

    // directed rows: extremes and bit patterns, all in the first frame after
    // reset, so every output is zero and frame_last is low
    row_t rows [25];
    initial begin
        logic signed [SB-1:0] pat [0:24];
        pat = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, -24'sd1, 24'sd1,
                24'sh555555, 24'shAAAAAA, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
                24'sh800000, 24'sd0, 24'sd0, 24'sd5, 24'sd5,
                -24'sd5, 24'sh7FFFFE, 24'sh800001, 24'sh0F0F0F, 24'shF0F0F0,
                24'sh400000, 24'shC00000, 24'sh000100, 24'shFFFF00, 24'sh123456};
        foreach (rows[i]) begin
            rows[i].sample      = pat[i];
            rows[i].want_sample = '0;
            rows[i].want_last   = 1'b0;
        end
    end

    // stimulus
    initial begin
        beat_t b;
        int f;
        int p;
        long_hold = 0;
        for (int i = 0; i <= N; i++) begin
            gather_bins[i] = '0;
            sorted_bins[i] = '0;
        end
        frame_pos    = 0;
        m_rotation   = 9'sd0;
        m_grains     = 9'd1;
        m_descending = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (f = 0; f < FRAMES; f++) begin
            // registers change only while the block is idle
            case (f)
                0: begin
                    write_reg(REG_ROTATION, 9'h101);     // -255
                    write_reg(REG_GRAIN_COUNT, 9'd0);    // zero grains
                    write_reg(REG_DESCENDING, 9'd0);
                end
                1: begin
                    write_reg(REG_ROTATION, 9'h0FF);     // 255
                    write_reg(REG_GRAIN_COUNT, 9'd256);  // one bin per grain
                    write_reg(REG_DESCENDING, 9'd1);
                end
                2: begin
                    write_reg(REG_ROTATION, 9'h000);
                    write_reg(REG_GRAIN_COUNT, 9'd1);
                    write_reg(REG_DESCENDING, 9'd0);
                end
                3: begin
                    write_reg(REG_ROTATION, 9'd100);
                    write_reg(REG_GRAIN_COUNT, 9'h1FF);  // more grains than bins
                    write_reg(REG_DESCENDING, 9'd1);
                end
                4: begin
                    write_reg(REG_ROTATION, 9'($urandom));
                    write_reg(REG_GRAIN_COUNT, 9'($urandom_range(1, 256)));
                    write_reg(REG_DESCENDING, 9'($urandom_range(0, 1)));
                end
                default: begin
                    write_reg(REG_ROTATION, 9'($urandom));
                    write_reg(REG_GRAIN_COUNT, 9'($urandom_range(2, 12)));
                    write_reg(REG_DESCENDING, 9'($urandom_range(0, 1)));
                end
            endcase

            for (p = 0; p < FRAME && beats_in < ITEMS; p++) begin
                if (f == 2 && p == 100)
                    long_hold = 1;   // receiver backs off while we keep offering
                if (f == 1 && p == 200) begin
                    // hold the input until every output has come back
                    in_valid <= 1'b0;
                    while (pending_beats.size() != 0)
                        @(posedge clk);
                end
                if (f == 0 && p < 25) begin
                    send(rows[p].sample);
                    b = frame_beat(rows[p].sample);
                    // typed expectation replaces the model's for these rows
                    b.sample = rows[p].want_sample;
                    b.last   = rows[p].want_last;
                    pending_beats.push_back(b);
                    frame_pos++;
                end else begin
                    send(rand_sample());
                    take_beat(in_sample);
                end
            end
            in_valid <= 1'b0;
            drain();
        end

        $display("covered %0d beats in and %0d out, two sorted frames and part of a third",
                 beats_in, beats_out);
        $display("settings spanned rotation extremes, zero and one-per-bin grain counts, both orders");
        if (errors == 0)
            $display("spectral_grain_sorter regression: pass");
        else
            $display("spectral_grain_sorter regression: fail");
        $finish;
    end

    // output side: random stall per beat, one long hold on request
    initial begin
        int gap;
        beat_t want;
        bit held;
        held = 0;
        @(posedge rst_n);
        forever begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 7) == 0)
                gap = 0;
            if (long_hold && !held) begin
                held = 1;
                gap = 600;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            beats_out++;
            if (pending_beats.size() == 0) begin
                report("output beat with nothing expected");
            end else begin
                want = pending_beats.pop_front();
                if (out_sample !== want.sample)
                    report($sformatf("out_sample %0d, expected %0d", out_sample, want.sample));
                if (frame_last !== want.last)
                    report($sformatf("frame_last %0b, expected %0b", frame_last, want.last));
            end
        end
    end

    // watchdog: cycles with no beat on either side
    int quiet = 0;
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("timeout with %0d beats outstanding", pending_beats.size());
            $display("spectral_grain_sorter regression: fail");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sgs_pkg.sv
sv/sgs_front.sv
sv/sgs_back.sv
sv/spectral_grain_sorter.sv
tb/tb.sv
